FILE: hw/rtl/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
// Used by the channel interfaces and every RTL module of the block.
package lps_pkg;

  localparam int unsigned IN_COORD_W  = 16;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned ERR_W       = 17;
  localparam int unsigned COLOUR_W    = 32;
  localparam int unsigned DIM_W       = 15;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 15'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Line setup handed from the input stage to the stepper.
  typedef struct packed {
    op_t                          op;
    logic signed [IN_COORD_W-1:0] x1;
    logic signed [IN_COORD_W-1:0] y1;
    logic [LEN_W-1:0]             major_len;
    logic [LEN_W-1:0]             minor_len;
    logic                         x_dir_neg;
    logic                         y_dir_neg;
    logic                         x_is_major;
    logic [COLOUR_W-1:0]          colour;
  } setup_t;

endpackage

FILE: hw/rtl/lps_in_if.sv
// Input word channel of the line pixel stepper: command and line endpoints.
// Depends on lps_pkg for field widths.
interface lps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [lps_pkg::IN_COORD_W-1:0] start_x;
  logic signed [lps_pkg::IN_COORD_W-1:0] start_y;
  logic signed [lps_pkg::IN_COORD_W-1:0] end_x;
  logic signed [lps_pkg::IN_COORD_W-1:0] end_y;
  logic [lps_pkg::COLOUR_W-1:0]          pixel_colour;

  modport source (output valid, op, start_x, start_y, end_x, end_y, pixel_colour,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, pixel_colour,
                  output ready);
endinterface

FILE: hw/rtl/lps_out_if.sv
// Pixel word channel of the line pixel stepper.
// Depends on lps_pkg for field widths.
interface lps_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lps_pkg::IN_COORD_W-1:0] out_x;
  logic signed [lps_pkg::IN_COORD_W-1:0] out_y;
  logic [lps_pkg::COLOUR_W-1:0]          out_colour;
  logic                                  visible;
  logic                                  last;

  modport source (output valid, out_x, out_y, out_colour, visible, last, input ready);
  modport sink   (input valid, out_x, out_y, out_colour, visible, last, output ready);
endinterface

FILE: hw/rtl/lps_cfg_if.sv
// Register write channel of the line pixel stepper.
// Depends on lps_pkg for index and data widths.
interface lps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lps_pkg::CFG_INDEX_W-1:0]  index;
  logic [lps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/line_pixel_stepper.sv
// Line pixel stepper: integer (Bresenham) line rasterizer with clipping. A start
// word (op 0) loads both endpoints and the colour and returns the first pixel;
// each step word (op 1) returns the next one, with a visible flag for pixels
// inside image_width x image_height and a last flag. One word is taken per clock
// while the pixel output is not stalled; each word passes through the setup
// register (endpoint difference, abs, axis pick) and then the line state, which
// is also the result register. The per-step add, compare and subtract on the
// error term sets the clock. Depends on lps_pkg, the lps_*_if interfaces,
// lps_setup and lps_stepper.
module line_pixel_stepper #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  lps_in_if.sink    items,
  lps_out_if.source pixels,
  lps_cfg_if.sink   cfg
);

  logic [lps_pkg::DIM_W-1:0] image_width;
  logic [lps_pkg::DIM_W-1:0] image_height;
  logic                      stage_valid;
  lps_pkg::setup_t           stage;
  logic                      advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lps_pkg::WIDTH_RESET;
      image_height <= lps_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lps_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg.data[lps_pkg::DIM_W-1:0];
        end
        lps_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data[lps_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lps_setup u_setup (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  lps_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .advance      (advance),
    .image_width  (image_width),
    .image_height (image_height),
    .pixels       (pixels)
  );

endmodule

FILE: hw/rtl/lps_setup.sv
// Input stage: registers each word together with its line setup
// (direction, major axis, axis lengths). Depends on lps_pkg and lps_in_if.
module lps_setup (
  input  logic             clk,
  input  logic             rst,
  lps_in_if.sink           items,
  input  logic             advance,
  output logic             stage_valid,
  output lps_pkg::setup_t  stage
);

  logic signed [lps_pkg::IN_COORD_W:0] dx;
  logic signed [lps_pkg::IN_COORD_W:0] dy;
  logic [lps_pkg::IN_COORD_W:0]        dx_abs;
  logic [lps_pkg::IN_COORD_W:0]        dy_abs;
  logic [lps_pkg::LEN_W-1:0]           adx;
  logic [lps_pkg::LEN_W-1:0]           ady;
  logic                                x_major;
  lps_pkg::setup_t                     stage_next;
  logic                                take;

  assign items.ready = !stage_valid || advance;
  assign take        = items.valid && items.ready;

  always_comb begin
    dx      = (lps_pkg::IN_COORD_W+1)'(items.end_x) - (lps_pkg::IN_COORD_W+1)'(items.start_x);
    dy      = (lps_pkg::IN_COORD_W+1)'(items.end_y) - (lps_pkg::IN_COORD_W+1)'(items.start_y);
    dx_abs  = dx[lps_pkg::IN_COORD_W] ? -dx : dx;
    dy_abs  = dy[lps_pkg::IN_COORD_W] ? -dy : dy;
    // |difference| of two 16-bit values never exceeds 65535
    adx     = dx_abs[lps_pkg::LEN_W-1:0];
    ady     = dy_abs[lps_pkg::LEN_W-1:0];
    x_major = adx > ady;

    stage_next.op         = lps_pkg::op_t'(items.op);
    stage_next.x1         = items.start_x;
    stage_next.y1         = items.start_y;
    stage_next.major_len  = x_major ? adx : ady;
    stage_next.minor_len  = x_major ? ady : adx;
    // zero difference counts as negative; it never moves anyway
    stage_next.x_dir_neg  = dx[lps_pkg::IN_COORD_W] || (dx == '0);
    stage_next.y_dir_neg  = dy[lps_pkg::IN_COORD_W] || (dy == '0);
    stage_next.x_is_major = x_major;
    stage_next.colour     = items.pixel_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= stage_next;
    end
  end

endmodule

FILE: hw/rtl/lps_stepper.sv
// Line state and pixel result register: loads a line on start, takes one
// Bresenham step per step word until the line ends. Depends on lps_pkg and lps_out_if.
module lps_stepper #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            stage_valid,
  input  lps_pkg::setup_t                 stage,
  output logic                            advance,
  input  logic [lps_pkg::DIM_W-1:0]       image_width,
  input  logic [lps_pkg::DIM_W-1:0]       image_height,
  lps_out_if.source                       pixels
);

  localparam int unsigned OUT_W = (COORD_BITS > lps_pkg::IN_COORD_W) ?
                                  COORD_BITS : lps_pkg::IN_COORD_W;
  localparam int unsigned CMP_W = (COORD_BITS > lps_pkg::DIM_W) ?
                                  COORD_BITS : lps_pkg::DIM_W;

  logic [COORD_BITS-1:0]        cur_x, cur_x_next;
  logic [COORD_BITS-1:0]        cur_y, cur_y_next;
  logic [lps_pkg::LEN_W-1:0]    major_len, major_len_next;
  logic [lps_pkg::LEN_W-1:0]    minor_len, minor_len_next;
  logic [lps_pkg::ERR_W-1:0]    err_acc, err_acc_next;
  logic [lps_pkg::LEN_W-1:0]    steps_done, steps_done_next;
  logic                         x_dir_neg, x_dir_neg_next;
  logic                         y_dir_neg, y_dir_neg_next;
  logic                         x_is_major, x_is_major_next;
  logic [lps_pkg::COLOUR_W-1:0] line_colour, line_colour_next;
  logic                         out_valid;
  logic                         vis_en, vis_en_next;
  logic                         last, last_next;

  logic [lps_pkg::ERR_W-1:0]    err_sum;
  logic                         minor_move;
  logic [COORD_BITS-1:0]        x_moved, y_moved;
  logic [OUT_W-1:0]             x_ext, y_ext;

  assign advance = stage_valid && (!out_valid || pixels.ready);

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    major_len_next   = major_len;
    minor_len_next   = minor_len;
    err_acc_next     = err_acc;
    steps_done_next  = steps_done;
    x_dir_neg_next   = x_dir_neg;
    y_dir_neg_next   = y_dir_neg;
    x_is_major_next  = x_is_major;
    line_colour_next = line_colour;

    err_sum    = err_acc + lps_pkg::ERR_W'(minor_len);
    minor_move = err_sum >= lps_pkg::ERR_W'(major_len);
    x_moved    = cur_x + (x_dir_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
    y_moved    = cur_y + (y_dir_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));

    case (stage.op)
      lps_pkg::OP_START: begin
        cur_x_next       = COORD_BITS'($signed(stage.x1));
        cur_y_next       = COORD_BITS'($signed(stage.y1));
        major_len_next   = stage.major_len;
        minor_len_next   = stage.minor_len;
        err_acc_next     = '0;
        steps_done_next  = '0;
        x_dir_neg_next   = stage.x_dir_neg;
        y_dir_neg_next   = stage.y_dir_neg;
        x_is_major_next  = stage.x_is_major;
        line_colour_next = stage.colour;
        vis_en_next      = 1'b1;
        last_next        = (stage.major_len == '0);
      end
      lps_pkg::OP_STEP: begin
        if (steps_done >= major_len) begin
          // line already ended: repeat final pixel, hidden
          vis_en_next = 1'b0;
          last_next   = 1'b1;
        end else begin
          err_acc_next    = minor_move ? err_sum - lps_pkg::ERR_W'(major_len) : err_sum;
          if (x_is_major) begin
            cur_x_next = x_moved;
            if (minor_move) begin
              cur_y_next = y_moved;
            end
          end else begin
            cur_y_next = y_moved;
            if (minor_move) begin
              cur_x_next = x_moved;
            end
          end
          steps_done_next = steps_done + 1'b1;
          vis_en_next     = 1'b1;
          last_next       = (lps_pkg::LEN_W'(steps_done + 1'b1) == major_len);
        end
      end
      default: begin
        vis_en_next = 1'b0;
        last_next   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      major_len   <= '0;
      minor_len   <= '0;
      err_acc     <= '0;
      steps_done  <= '0;
      x_dir_neg   <= 1'b0;
      y_dir_neg   <= 1'b0;
      x_is_major  <= 1'b0;
      line_colour <= '0;
      vis_en      <= 1'b0;
      last        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        cur_x       <= cur_x_next;
        cur_y       <= cur_y_next;
        major_len   <= major_len_next;
        minor_len   <= minor_len_next;
        err_acc     <= err_acc_next;
        steps_done  <= steps_done_next;
        x_dir_neg   <= x_dir_neg_next;
        y_dir_neg   <= y_dir_neg_next;
        x_is_major  <= x_is_major_next;
        line_colour <= line_colour_next;
        vis_en      <= vis_en_next;
        last        <= last_next;
        out_valid   <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the line state doubles as the result register; it only moves on advance
  assign x_ext = OUT_W'(cur_x);
  assign y_ext = OUT_W'(cur_y);

  assign pixels.valid      = out_valid;
  assign pixels.out_x      = x_ext[lps_pkg::IN_COORD_W-1:0];
  assign pixels.out_y      = y_ext[lps_pkg::IN_COORD_W-1:0];
  assign pixels.out_colour = line_colour;
  assign pixels.last       = last;
  assign pixels.visible    = vis_en && !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                             (CMP_W'(cur_x) < CMP_W'(image_width)) &&
                             (CMP_W'(cur_y) < CMP_W'(image_height));

endmodule

FILE: tb/sv/line_pixel_stepper_test.sv
// Self-checking bench for line_pixel_stepper: drives start and step words, predicts each
// pixel word and compares it, with random gaps, stalls and several image sizes.
// Depends on lps_pkg, lps_in_if, lps_out_if, lps_cfg_if and the line_pixel_stepper RTL.
module line_pixel_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        colour;
    logic               visible;
    logic               last;
  } pixel_t;

  // Line stepping predictor plus the queue of pixel words still owed by the block.
  class pixel_tracker;
    logic [lps_pkg::DIM_W-1:0] img_w;
    logic [lps_pkg::DIM_W-1:0] img_h;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        major;
    logic [15:0]        minor;
    logic [15:0]        steps;
    logic [16:0]        err;
    logic               neg_x;
    logic               neg_y;
    logic               x_major;
    logic [31:0]        colour;
    pixel_t             owed_pixels[$];
    int                 errors;
    int                 checked;
    int                 shown;
    int                 lines;

    function new();
      img_w = lps_pkg::WIDTH_RESET;
      img_h = lps_pkg::HEIGHT_RESET;
      pos_x = '0;
      pos_y = '0;
      major = '0;
      minor = '0;
      steps = '0;
      err = '0;
      neg_x = 1'b0;
      neg_y = 1'b0;
      x_major = 1'b0;
      colour = '0;
      errors = 0;
      checked = 0;
      shown = 0;
      lines = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return owed_pixels.size();
    endfunction

    function void write_reg(logic [lps_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lps_pkg::CFG_DATA_W-1:0] data);
      if (idx == lps_pkg::REG_IMAGE_WIDTH) img_w = data[lps_pkg::DIM_W-1:0];
      else if (idx == lps_pkg::REG_IMAGE_HEIGHT) img_h = data[lps_pkg::DIM_W-1:0];
    endfunction

    function pixel_t make_pixel(bit allow, bit is_last);
      int     px;
      int     py;
      pixel_t p;
      px = pos_x;
      py = pos_y;
      p.x = pos_x;
      p.y = pos_y;
      p.colour = colour;
      p.visible = allow && px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
      p.last = is_last;
      return p;
    endfunction

    function void take_word(lps_pkg::op_t op, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] ex, logic signed [15:0] ey,
                            logic [31:0] col);
      int dx;
      int dy;
      if (op == lps_pkg::OP_START) begin
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        neg_x = !(dx > 0);
        neg_y = !(dy > 0);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        x_major = dx > dy;
        major = x_major ? dx[15:0] : dy[15:0];
        minor = x_major ? dy[15:0] : dx[15:0];
        err = '0;
        steps = '0;
        pos_x = sx;
        pos_y = sy;
        colour = col;
        lines++;
        owed_pixels.push_back(make_pixel(1'b1, major == 0));
      end else if (steps >= major) begin
        // line done (or never started): repeat last pixel, hidden
        owed_pixels.push_back(make_pixel(1'b0, 1'b1));
      end else begin
        err = err + minor;
        if (x_major) begin
          pos_x = neg_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
          if (err >= major) begin
            err = err - major;
            pos_y = neg_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
          end
        end else begin
          pos_y = neg_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
          if (err >= major) begin
            err = err - major;
            pos_x = neg_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
          end
        end
        steps = steps + 16'd1;
        owed_pixels.push_back(make_pixel(1'b1, steps == major));
      end
    endfunction

    task check_pixel(pixel_t got);
      pixel_t exp;
      if (owed_pixels.size() == 0) begin
        report($sformatf("pixel word (%0d,%0d) with nothing owed", got.x, got.y));
      end else begin
        exp = owed_pixels.pop_front();
        checked++;
        if (got.visible === 1'b1) shown++;
        if (got.x !== exp.x)
          report($sformatf("out_x %0d, want %0d", got.x, exp.x));
        if (got.y !== exp.y)
          report($sformatf("out_y %0d, want %0d", got.y, exp.y));
        if (got.colour !== exp.colour)
          report($sformatf("out_colour %h, want %h", got.colour, exp.colour));
        if (got.visible !== exp.visible)
          report($sformatf("visible %b, want %b at (%0d,%0d)", got.visible, exp.visible,
                           exp.x, exp.y));
        if (got.last !== exp.last)
          report($sformatf("last %b, want %b at (%0d,%0d)", got.last, exp.last,
                           exp.x, exp.y));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lps_in_if  items_if ();
  lps_out_if pix_if ();
  lps_cfg_if cfg_if ();

  line_pixel_stepper uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .pixels (pix_if),
    .cfg    (cfg_if)
  );

  pixel_tracker tracker = new();

  int words_sent = 0;
  int sizes_used = 1;
  int cur_w = 1024;
  int cur_h = 768;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int coord_clamp(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int line_span(int sx, int sy, int ex, int ey);
    int ax;
    int ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return (ax > ay) ? ax : ay;
  endfunction

  // pixel sink: ready low for random stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pix_if.ready = 1'b0;
      stall_left--;
    end else begin
      pix_if.ready = 1'b1;
      if (stalls_on && $urandom_range(0, 99) < 15) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) tracker.write_reg(cfg_if.index, cfg_if.data);
      if (items_if.valid && items_if.ready)
        tracker.take_word(lps_pkg::op_t'(items_if.op), items_if.start_x, items_if.start_y,
                          items_if.end_x, items_if.end_y, items_if.pixel_colour);
      if (pix_if.valid && pix_if.ready) begin
        got.x = pix_if.out_x;
        got.y = pix_if.out_y;
        got.colour = pix_if.out_colour;
        got.visible = pix_if.visible;
        got.last = pix_if.last;
        tracker.check_pixel(got);
      end
    end
  end

  task automatic send_word(lps_pkg::op_t op, int sx, int sy, int ex, int ey,
                           logic [31:0] col);
    int gap;
    @(negedge clk);
    items_if.valid = 1'b1;
    items_if.op = op;
    items_if.start_x = sx[15:0];
    items_if.start_y = sy[15:0];
    items_if.end_x = ex[15:0];
    items_if.end_y = ey[15:0];
    items_if.pixel_colour = col;
    do @(posedge clk); while (!items_if.ready);
    words_sent++;
    gap = (gaps_on && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      items_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // step words carry junk in the unused fields
  task automatic step_words(int n);
    repeat (n) send_word(lps_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic line_words(int sx, int sy, int ex, int ey, logic [31:0] col, int n);
    send_word(lps_pkg::OP_START, sx, sy, ex, ey, col);
    step_words(n);
  endtask

  task automatic drain();
    @(negedge clk);
    items_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(lps_pkg::cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val[lps_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_image(int w, int h);
    drain();
    write_reg(lps_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lps_pkg::REG_IMAGE_HEIGHT, h);
    cur_w = w;
    cur_h = h;
    sizes_used++;
  endtask

  task automatic random_lines(int n);
    int target;
    int kind;
    int sx;
    int sy;
    int ex;
    int ey;
    int reach;
    int steps;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 10) gaps_on = !gaps_on;
      if ($urandom_range(0, 99) < 10) stalls_on = !stalls_on;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // short line around an image edge
        reach = ($urandom_range(0, 99) < 80) ? 12 : 60;
        sx = coord_clamp(($urandom_range(0, 1) ? 0 : cur_w) + int'($urandom_range(0, 40)) - 20);
        sy = coord_clamp(($urandom_range(0, 1) ? 0 : cur_h) + int'($urandom_range(0, 40)) - 20);
        ex = coord_clamp(sx + int'($urandom_range(0, 2 * reach)) - reach);
        ey = coord_clamp(sy + int'($urandom_range(0, 2 * reach)) - reach);
        steps = line_span(sx, sy, ex, ey);
        if ($urandom_range(0, 99) < 10) steps = $urandom_range(0, steps);
        else if ($urandom_range(0, 99) < 15) steps += $urandom_range(1, 3);
        line_words(sx, sy, ex, ey, $urandom, steps);
      end else if (kind < 77) begin
        // short line hugging the coordinate extremes
        sx = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 8))
                                  : -32768 + int'($urandom_range(0, 8));
        sy = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 8))
                                  : -32768 + int'($urandom_range(0, 8));
        ex = coord_clamp(sx + int'($urandom_range(0, 16)) - 8);
        ey = coord_clamp(sy + int'($urandom_range(0, 16)) - 8);
        line_words(sx, sy, ex, ey, $urandom, line_span(sx, sy, ex, ey) + 1);
      end else if (kind < 90) begin
        // any endpoints, cut short by the next start
        line_words(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                   int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                   $urandom, $urandom_range(0, 4));
      end else begin
        step_words($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    items_if.valid = 1'b0;
    items_if.op = lps_pkg::OP_STEP;
    items_if.start_x = '0;
    items_if.start_y = '0;
    items_if.end_x = '0;
    items_if.end_y = '0;
    items_if.pixel_colour = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lps_pkg::REG_IMAGE_WIDTH;
    cfg_if.data = '0;
    pix_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: steps before any start, single point, axis and diagonal lines, extremes
    step_words(2);
    line_words(5, 5, 5, 5, 32'h0000_0000, 1);
    line_words(0, 0, 3, 0, 32'hFFFF_FFFF, 3);
    line_words(2, 1, 0, -3, 32'hA5A5_5A5A, 5);
    line_words(1020, 765, 1025, 770, 32'h0123_4567, 5);
    line_words(-32768, -32768, 32767, 32767, 32'h8000_0001, 2);
    line_words(32767, 32767, -32768, -32768, 32'h7FFF_FFFE, 1);

    random_lines(130);
    set_image(1, 1);
    random_lines(130);
    set_image(32767, 32767);
    random_lines(130);
    set_image(0, 500);
    random_lines(130);
    set_image(640, 0);
    random_lines(130);
    set_image($urandom_range(1, 32767), $urandom_range(1, 32767));
    random_lines(130);
    set_image(1024, 768);
    random_lines(130);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d pixel words never arrived", tracker.pending()));
    $display("Sent %0d words (%0d lines) over %0d image sizes;", words_sent, tracker.lines,
             sizes_used);
    $display("checked %0d pixel words, %0d of them visible.", tracker.checked, tracker.shown);
    if (tracker.errors == 0) begin
      $display("line_pixel_stepper_test: PASS");
    end else begin
      $display("line_pixel_stepper_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d pixel words owed", tracker.pending());
    $display("line_pixel_stepper_test: FAIL");
    $finish;
  end

endmodule
